[hw/rtl/lrs_pkg.sv]
// lrs_pkg: shared constants for the red-lsb steganography codec
// used by lsb_red_stego_codec and its port checker; no dependencies
package lrs_pkg;

  // status codes reported with every item
  localparam logic [1:0] ST_WORKING  = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;
  localparam logic [1:0] ST_BAD_HDR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE        = 2'd0;
  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd2;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // pixels that carry the 32-bit length header
  localparam int unsigned HEADER_PIXELS = 32;
  localparam int unsigned REG_W         = 32;

endpackage

[hw/rtl/lsb_red_stego_codec.sv]
// lsb_red_stego_codec: hides or recovers a payload in the red lsb of a pixel stream
// depends on lrs_pkg
//
// Usage: one pixel per input item (start_of_image, red_in, payload_byte), one
// result item per pixel (red_out, data_byte, data_valid, data_last, status).
// Both channels are valid/ready. The configuration port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) sets mode, pixel_count and payload_length; write it while idle.
// In embed mode the first 32 pixels carry the length, lsb first, then each
// payload byte takes 8 pixels; an image too small is flagged as status 2 and
// passes unchanged. In extract mode the header is decoded, checked against
// pixel_count and the bytes are emitted with data_last on the final one.
// Each item passes through the input register, then the result register.
// Throughput: one pixel per cycle while out_ready_i stays high; the position counter
// and bit insert/extract are combinational, so pixels may follow back to back.
// Reset clears mode, counts and all codec state; the first pixel after reset
// counts as position 0 even without start_of_image.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops only when both stages are occupied.
module lsb_red_stego_codec #(
  parameter int unsigned PIXEL_COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [lrs_pkg::REG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            start_of_image_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      payload_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      red_out_o,
  output logic [7:0]                      data_byte_o,
  output logic                            data_valid_o,
  output logic                            data_last_o,
  output logic [1:0]                      status_o
);
  import lrs_pkg::*;

  localparam int unsigned PW   = PIXEL_COUNT_WIDTH + 4;
  localparam int unsigned CW   = (PW > 36) ? PW : 36;
  localparam int unsigned PCSW = (PIXEL_COUNT_WIDTH < REG_W) ? PIXEL_COUNT_WIDTH : REG_W;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  // configuration
  logic             mode_q;
  logic [PCSW-1:0]  pix_cnt_q;
  logic [31:0]      pay_len_q;

  // input register
  logic       s1_valid_q;
  logic       s1_sof_q;
  logic [7:0] s1_red_q;
  logic [7:0] s1_pay_q;

  // codec state
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   len_q, len_d;
  logic [7:0]    bs_q, bs_d;
  logic [1:0]    st_q, st_d;

  // result register
  logic       out_valid_q;
  logic [7:0] red_out_q, red_out_d;
  logic [7:0] dbyte_q, dbyte_d;
  logic       dvalid_q, dvalid_d;
  logic       dlast_q, dlast_d;

  logic s2_ready, advance;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_EMBED;
      pix_cnt_q <= '0;
      pay_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:        mode_q    <= cfg_wdata_i[0];
        CFG_PIXEL_COUNT: pix_cnt_q <= cfg_wdata_i[PCSW-1:0];
        CFG_PAYLOAD_LEN: pay_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_sof_q <= start_of_image_i;
      s1_red_q <= red_in_i;
      s1_pay_q <= payload_byte_i;
    end
  end

  always_comb begin
    logic [PW-1:0] p;
    logic [CW-1:0] p_c, end_c, pc_c, need_c;
    logic [CW:0]   p1;
    logic          bit_v, in_hdr, last_pix;

    pos_d     = s1_sof_q ? '0 : pos_q;
    len_d     = s1_sof_q ? '0 : len_q;
    bs_d      = s1_sof_q ? '0 : bs_q;
    st_d      = s1_sof_q ? ST_WORKING : st_q;
    p         = pos_d;
    red_out_d = s1_red_q;
    dbyte_d   = '0;
    dvalid_d  = 1'b0;
    dlast_d   = 1'b0;
    bit_v     = s1_red_q[0];
    end_c     = '0;
    last_pix  = 1'b0;
    p_c       = CW'(p);
    p1        = {1'b0, p_c} + (CW+1)'(1);
    pc_c      = CW'(pix_cnt_q);
    in_hdr    = (p < PW'(HEADER_PIXELS));
    need_c    = CW'(({4'b0, pay_len_q} + 36'd4) << 3);

    if (mode_q == MODE_EMBED) begin
      if (p == '0 && st_d == ST_WORKING) begin
        len_d = pay_len_q;
        if (pc_c < need_c) st_d = ST_CAPACITY;
      end
      end_c    = CW'({len_d, 3'b000}) + CW'(HEADER_PIXELS);
      last_pix = (p1 >= {1'b0, end_c});
      if (st_d == ST_WORKING) begin
        if (in_hdr) begin
          bit_v = len_d[p[4:0]];
        end else if (p_c < end_c) begin
          if (p[2:0] == 3'd0) bs_d = s1_pay_q;
          bit_v = bs_d[0];
          bs_d  = {1'b0, bs_d[7:1]};
        end
        red_out_d = {s1_red_q[7:1], bit_v};
        if (last_pix) st_d = ST_DONE;
      end
    end else if (st_d == ST_WORKING) begin
      if (in_hdr) begin
        len_d = len_d | (32'(bit_v) << p[4:0]);
        if (p[4:0] == 5'd31) begin
          if ((CW'({len_d, 3'b000}) + CW'(HEADER_PIXELS)) > pc_c) st_d = ST_BAD_HDR;
          else if (len_d == '0) st_d = ST_DONE;
        end
      end else begin
        end_c = CW'({len_d, 3'b000}) + CW'(HEADER_PIXELS);
        bs_d  = {bit_v, bs_d[7:1]};
        if (p[2:0] == 3'd7) begin
          dbyte_d  = bs_d;
          dvalid_d = 1'b1;
          if (p1 >= {1'b0, end_c}) begin
            dlast_d = 1'b1;
            st_d    = ST_DONE;
          end
        end
      end
    end

    if (pos_d < POS_MAX) pos_d = pos_d + PW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      bs_q        <= '0;
      st_q        <= ST_WORKING;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) out_valid_q <= s1_valid_q;
      if (advance) begin
        pos_q <= pos_d;
        len_q <= len_d;
        bs_q  <= bs_d;
        st_q  <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_out_q <= red_out_d;
      dbyte_q   <= dbyte_d;
      dvalid_q  <= dvalid_d;
      dlast_q   <= dlast_d;
    end
  end

  // status is the state register itself, which only changes with the result
  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_out_q;
  assign data_byte_o  = dbyte_q;
  assign data_valid_o = dvalid_q;
  assign data_last_o  = dlast_q;
  assign status_o     = st_q;

endmodule

[hw/rtl/lrs_checker.sv]
// lrs_checker: port-level assertions for lsb_red_stego_codec, bound to the top level
// depends on lrs_pkg
module lrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic [7:0] data_byte_o,
  input logic       data_valid_o,
  input logic       data_last_o,
  input logic [1:0] status_o
);
  import lrs_pkg::*;

  // last byte must also be a valid byte
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_last_o |-> data_valid_o)
    else $error("data_last without data_valid");

  // the last byte finishes the image
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_last_o |-> status_o == ST_DONE)
    else $error("data_last with status not finished");

  // no byte while the status says the header was rejected or the image is full
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> status_o == ST_WORKING || status_o == ST_DONE)
    else $error("byte emitted with error status");

  // a stalled item holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(data_byte_o) && $stable(data_valid_o) && $stable(status_o))
    else $error("result changed while stalled");

endmodule

bind lsb_red_stego_codec lrs_checker u_lrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_out_o    (red_out_o),
  .data_byte_o  (data_byte_o),
  .data_valid_o (data_valid_o),
  .data_last_o  (data_last_o),
  .status_o     (status_o)
);
